/* rtl/core/gmfps_pkg.sv */
// Shared constants for the grid maximum falling path sum block.
// Register map and fixed field widths; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gmfps_pkg;

  // Configuration register map
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_NUM_ROWS = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_NUM_COLS = 1'd1;

  // Register widths
  localparam int unsigned ROWS_W  = 16;
  localparam int unsigned NCOLS_W = 9;

  // Reset values
  localparam logic [ROWS_W-1:0]  ROWS_RST  = 16'd1;
  localparam logic [NCOLS_W-1:0] NCOLS_RST = 9'd1;

endpackage : gmfps_pkg

`default_nettype wire

/* rtl/core/grid_max_falling_path_sum_top.sv */
// Grid maximum falling path sum: one row of best sums in a synchronous RAM.
// Depends on gmfps_pkg for the register map and register widths.
//
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: cell_value
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: max_sum
//  cfg       | in  | cfg_valid_i / cfg_ready_o     | cfg_addr_i, cfg_data_i
//
// One cell per cycle: issue stage reads two row-RAM entries, compute stage does
// the max-of-three, the saturating add and the write back. A same-cycle write
// to an entry being read is forwarded. The last cell of a grid goes from the
// compute stage register into the output register, which then holds the result.
// Input stalls only while a finished result waits in the output register and
// the next grid's result is ready behind it.
// Reset is asynchronous; no clearing pass, the row RAM is written before use.
`timescale 1ns / 1ps
`default_nettype none

module grid_max_falling_path_sum_top #(
  parameter int unsigned COLS_MAX    = 256,
  parameter int unsigned VALUE_WIDTH = 16,
  parameter int unsigned SUM_WIDTH   = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // input cells
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // [VALUE_WIDTH-1:0] cell_value
  // results
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [((SUM_WIDTH+7)/8)*8-1:0]            m_axis_tdata,  // [SUM_WIDTH-1:0] max_sum
  // configuration writes
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [gmfps_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  wire logic [gmfps_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import gmfps_pkg::*;

  localparam int unsigned OUT_W = ((SUM_WIDTH + 7) / 8) * 8;
  localparam int unsigned CW    = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
  localparam int unsigned CNT_W = (CW + 1 > NCOLS_W) ? CW + 1 : NCOLS_W;
  localparam int unsigned WW    = (VALUE_WIDTH > SUM_WIDTH) ? VALUE_WIDTH : SUM_WIDTH;

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam logic [CNT_W-1:0]            COLS_LIM = CNT_W'(COLS_MAX);
  localparam logic [CW-1:0]               COL_TOP  = CW'(COLS_MAX - 1);

  // Compute-stage contents
  typedef struct packed {
    logic                        row0;
    logic                        has_left;
    logic                        has_right;
    logic                        last_row;
    logic                        last_col;
    logic [CW-1:0]               col;
    logic signed [SUM_WIDTH-1:0] value;
  } s1_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [ROWS_W-1:0]  num_rows_q;
  logic [NCOLS_W-1:0] num_cols_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= ROWS_RST;
      num_cols_q <= NCOLS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        REG_NUM_ROWS: num_rows_q <= cfg_data_i[ROWS_W-1:0];
        REG_NUM_COLS: num_cols_q <= cfg_data_i[NCOLS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Issue stage: position, grid edges, RAM read addresses
  logic [CW-1:0]     col_q, col_d;
  logic [ROWS_W-1:0] row_q, row_d;
  logic [CNT_W-1:0]  cols_nz, cols_eff;
  logic [ROWS_W:0]   rows_eff;
  logic              last_col, last_row;
  logic [CW-1:0]     addr_b;
  logic              in_acc;
  logic signed [WW-1:0]        v_w;
  logic signed [SUM_WIDTH-1:0] v_sat;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign cols_nz  = (num_cols_q == '0) ? CNT_W'(1) : CNT_W'(num_cols_q);
  assign cols_eff = (cols_nz > COLS_LIM) ? COLS_LIM : cols_nz;
  assign rows_eff = (num_rows_q == '0) ? (ROWS_W+1)'(1) : {1'b0, num_rows_q};
  assign last_col = (CNT_W'(col_q) + CNT_W'(1)) >= cols_eff;
  assign last_row = ({1'b0, row_q} + (ROWS_W+1)'(1)) >= rows_eff;
  // right neighbor address; wraps only where the neighbor is not used
  assign addr_b   = (col_q == COL_TOP) ? '0 : col_q + CW'(1);

  // cell value limited to the sum range
  assign v_w   = WW'($signed(s_axis_tdata[VALUE_WIDTH-1:0]));
  assign v_sat = (v_w > WW'(SUM_MAX)) ? SUM_MAX :
                 (v_w < WW'(SUM_MIN)) ? SUM_MIN : v_w[SUM_WIDTH-1:0];

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROWS_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Compute stage register
  s1_t  s1_q, s1_d;
  logic s1_valid_q, s1_valid_d;
  logic s1_fire, s1_hold, s1_final;
  logic out_valid_q, out_valid_d;

  assign s1_final      = s1_q.last_row && s1_q.last_col;
  assign s1_hold       = s1_valid_q && s1_final && out_valid_q && !m_axis_tready;
  assign s1_fire       = s1_valid_q && !s1_hold;
  assign s_axis_tready = !s1_hold;

  always_comb begin
    s1_d           = s1_q;
    s1_valid_d     = s1_valid_q && !s1_fire;
    if (in_acc) begin
      s1_valid_d     = 1'b1;
      s1_d.row0      = (row_q == '0);
      s1_d.has_left  = (col_q != '0);
      s1_d.has_right = !last_col;
      s1_d.last_row  = last_row;
      s1_d.last_col  = last_col;
      s1_d.col       = col_q;
      s1_d.value     = v_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // ---------------------------------------------------------------------------
  // Row RAM with registered reads and write-to-read forwarding
  logic signed [SUM_WIDTH-1:0] row_mem [COLS_MAX];
  logic signed [SUM_WIDTH-1:0] rd_a_q, rd_b_q, fwd_data_q;
  logic                        fwd_a_q, fwd_b_q;
  logic signed [SUM_WIDTH-1:0] cell_sum;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      row_mem[s1_q.col] <= cell_sum;
    end
    if (in_acc) begin
      rd_a_q     <= row_mem[col_q];
      rd_b_q     <= row_mem[addr_b];
      fwd_data_q <= cell_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_a_q <= 1'b0;
      fwd_b_q <= 1'b0;
    end else if (in_acc) begin
      fwd_a_q <= s1_fire && (s1_q.col == col_q);
      fwd_b_q <= s1_fire && (s1_q.col == addr_b);
    end
  end

  // ---------------------------------------------------------------------------
  // Best of three neighbors, saturating add
  logic signed [SUM_WIDTH-1:0] above, right, best_l, best;
  logic signed [SUM_WIDTH:0]   sum_w;
  logic signed [SUM_WIDTH-1:0] old_left_q, old_left_d;
  logic signed [SUM_WIDTH-1:0] bsf_q, bsf_d;
  logic signed [SUM_WIDTH-1:0] result;

  assign above  = fwd_a_q ? fwd_data_q : rd_a_q;
  assign right  = fwd_b_q ? fwd_data_q : rd_b_q;
  assign best_l = (s1_q.has_left && (old_left_q > above)) ? old_left_q : above;
  assign best   = (s1_q.has_right && (right > best_l)) ? right : best_l;
  assign sum_w  = {best[SUM_WIDTH-1], best} + {s1_q.value[SUM_WIDTH-1], s1_q.value};

  always_comb begin
    priority if (s1_q.row0) begin
      cell_sum = s1_q.value;
    end else if (sum_w[SUM_WIDTH] != sum_w[SUM_WIDTH-1]) begin
      cell_sum = sum_w[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end else begin
      cell_sum = sum_w[SUM_WIDTH-1:0];
    end
  end

  assign result = (cell_sum > bsf_q) ? cell_sum : bsf_q;

  // left neighbor and running maximum of the final row
  always_comb begin
    old_left_d = old_left_q;
    bsf_d      = bsf_q;
    if (s1_fire) begin
      old_left_d = s1_q.last_col ? '0 : above;
      if (s1_final) begin
        bsf_d = SUM_MIN;
      end else if (s1_q.last_row) begin
        bsf_d = result;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_left_q <= '0;
      bsf_q      <= SUM_MIN;
    end else begin
      old_left_q <= old_left_d;
      bsf_q      <= bsf_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  logic [SUM_WIDTH-1:0] out_data_q;

  assign out_valid_d = (s1_fire && s1_final) || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_final) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(out_data_q);

  // ---------------------------------------------------------------------------
  // Assertions
  a_hold_needs_full_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_hold |-> (out_valid_q && s1_valid_q))
    else $error("compute stage held without a pending result");

  a_final_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_final) |=> out_valid_q)
    else $error("final cell did not produce a result");

  a_row_end_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_col) |=> (col_q == '0))
    else $error("column position not cleared at end of row");

  a_fwd_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(in_acc) && fwd_a_q) |-> $past(s1_fire))
    else $error("forwarding flagged without a write");

endmodule : grid_max_falling_path_sum_top

`default_nettype wire

/* tb/gmfps_path_checker.sv */
`timescale 1ns / 1ps
// Checker for the grid maximum falling path sum block: watches the cell, result
// and configuration channels, predicts every grid maximum and compares.
// Depends on gmfps_pkg for the register map and register widths.

module gmfps_path_checker #(
  parameter int unsigned COLS_MAX = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // cell requests
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,   // [15:0] cell_value
  // result requests
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [31:0]                      m_axis_tdata,   // [31:0] max_sum
  // register write requests
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [gmfps_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [gmfps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // status for the stimulus side
  output int                               errors_o,
  output int                               pending_o
);
  import gmfps_pkg::*;

  typedef logic signed [31:0] sum_t;

  localparam sum_t SUM_HI = 32'sh7fff_ffff;
  localparam sum_t SUM_LO = 32'sh8000_0000;

  // Predicted block state
  sum_t               path_row [COLS_MAX];
  sum_t               prev_left;
  sum_t               final_best;
  logic [15:0]        cur_row;
  logic [7:0]         cur_col;
  logic [ROWS_W-1:0]  rows_reg;
  logic [NCOLS_W-1:0] cols_reg;

  // Grid maxima still owed by the block, oldest first
  sum_t               max_sum_due [$];
  sum_t               want;
  int                 mismatches;

  function automatic sum_t add_sat(sum_t a, logic signed [15:0] v);
    longint s;
    s = longint'(a) + longint'(v);
    if (s > longint'(SUM_HI)) return SUM_HI;
    if (s < longint'(SUM_LO)) return SUM_LO;
    return sum_t'(s);
  endfunction

  // One cell of the raster: best of the three cells above plus its value
  task automatic fold_cell(input logic signed [15:0] v);
    int   rows_eff;
    int   cols_eff;
    int   c;
    bit   last_row;
    bit   last_col;
    sum_t above;
    sum_t best;
    sum_t node_sum;
    rows_eff = (rows_reg == '0) ? 1 : int'(rows_reg);
    cols_eff = (cols_reg == '0) ? 1 : int'(cols_reg);
    if (cols_eff > COLS_MAX) cols_eff = COLS_MAX;
    c        = int'(cur_col);
    last_col = (c + 1 >= cols_eff);
    last_row = (int'(cur_row) + 1 >= rows_eff);

    above = path_row[c];
    if (cur_row == '0) begin
      node_sum = sum_t'(v);
    end else begin
      best = above;
      if (c > 0 && prev_left > best) best = prev_left;
      if (!last_col && c + 1 < COLS_MAX && path_row[c+1] > best) best = path_row[c+1];
      node_sum = add_sat(best, v);
    end
    prev_left   = above;
    path_row[c] = node_sum;

    if (last_row && node_sum > final_best) final_best = node_sum;

    if (last_col) begin
      cur_col   = '0;
      prev_left = '0;
      if (last_row) begin
        max_sum_due.push_back(final_best);
        final_best = SUM_LO;
        cur_row    = '0;
      end else begin
        cur_row = cur_row + 16'd1;
      end
    end else begin
      cur_col = 8'(c + 1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (path_row[i]) path_row[i] = '0;
      prev_left  = '0;
      final_best = SUM_LO;
      cur_row    = '0;
      cur_col    = '0;
      rows_reg   = ROWS_RST;
      cols_reg   = NCOLS_RST;
      max_sum_due.delete();
      mismatches = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      // result side: compare against the oldest grid maximum
      if (m_axis_tvalid && m_axis_tready) begin
        if (max_sum_due.size() == 0) begin
          mismatches++;
          $display("%0t ns: max_sum mismatch, expected none, actual %0d",
                   $time, $signed(m_axis_tdata));
        end else begin
          want = max_sum_due.pop_front();
          if (m_axis_tdata !== want) begin
            mismatches++;
            $display("%0t ns: max_sum mismatch, expected %0d, actual %0d",
                     $time, want, $signed(m_axis_tdata));
          end
        end
      end

      // cell side: a cell taken at this edge still sees the old registers
      if (s_axis_tvalid && s_axis_tready) fold_cell(s_axis_tdata);

      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_addr_i == REG_NUM_ROWS) rows_reg = cfg_data_i[ROWS_W-1:0];
        else if (cfg_addr_i == REG_NUM_COLS) cols_reg = cfg_data_i[NCOLS_W-1:0];
      end

      errors_o  <= mismatches;
      pending_o <= max_sum_due.size();
    end
  end

endmodule

/* tb/grid_max_falling_path_sum_top_test.sv */
`timescale 1ns / 1ps
// Top of the grid maximum falling path sum testbench: clock, reset, cell and
// register stimulus, result back-pressure and the verdict. Needs gmfps_pkg,
// the block and gmfps_path_checker.

module grid_max_falling_path_sum_top_test;
  import gmfps_pkg::*;

  localparam int ITEMS         = 1650;
  localparam int DRAIN         = 8;
  localparam int LONG_HOLD     = 300;
  localparam int FINAL_GAPLESS = 250;
  localparam int STRESS_GRID   = 10;
  localparam int END_GUARD     = 20000;
  localparam int LIMIT_NS      = 3_000_000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata;   // [15:0] cell_value
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [31:0]           m_axis_tdata;   // [31:0] max_sum
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fails;
  int pending;
  int items_sent;
  int rows_eff;
  int cols_eff;
  bit tx_gaps;
  bit rx_gaps;
  bit stall_req;
  bit stall_seen;

  grid_max_falling_path_sum_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_addr_i    (cfg_addr),
    .cfg_data_i    (cfg_data)
  );

  gmfps_path_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_addr_i    (cfg_addr),
    .cfg_data_i    (cfg_data),
    .errors_o      (fails),
    .pending_o     (pending)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Hard stop in case the block hangs
  initial begin
    #LIMIT_NS;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random ready bursts, one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    stall_seen = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_req && !stall_seen) begin
        stall_seen = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Full-range values half the time, with the extremes and small numbers mixed in
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // One cell request; valid stays high into the next call unless a gap is taken
  task automatic send_cell(input logic [15:0] value);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Register write request; valid is kept high when another write follows
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data, input bit more);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    if (!more) cfg_valid <= 1'b0;
  endtask

  // Stop sending, wait for every owed result, then let the pipeline drain
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // New grid shape, written only once the block is idle
  task automatic set_shape(input logic [15:0] rows_data, input logic [15:0] cols_data);
    int cols9;
    wait_idle();
    cfg_write(REG_NUM_ROWS, rows_data, 1'b1);
    cfg_write(REG_NUM_COLS, cols_data, 1'b0);
    cols9    = int'(cols_data[NCOLS_W-1:0]);
    rows_eff = (rows_data == '0) ? 1 : int'(rows_data);
    cols_eff = (cols9 == 0) ? 1 : (cols9 > 256 ? 256 : cols9);
  endtask

  task automatic send_grid();
    for (int n = 0; n < rows_eff * cols_eff; n++) send_cell(pick_value());
  endtask

  initial begin
    int grid_no;
    int r;
    int k;
    int guard;
    bit reshape;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid     <= 1'b0;
    cfg_addr      <= '0;
    cfg_data      <= '0;
    tx_gaps     = 1'b0;
    rx_gaps     = 1'b0;
    stall_req   = 1'b0;
    items_sent  = 0;
    rows_eff    = 1;
    cols_eff    = 1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset shape is one by one: every cell is a grid of its own
    send_cell(16'h7fff);
    send_cell(16'h8000);

    // Two by three: left, up and right neighbours, edge columns skip one
    set_shape(16'd2, 16'd3);
    send_cell(16'd5);
    send_cell(-16'sd1);
    send_cell(16'd7);
    send_cell(16'd1);
    send_cell(16'd2);
    send_cell(16'd3);

    // Most negative values all the way down
    set_shape(16'd2, 16'd2);
    repeat (4) send_cell(16'h8000);

    // Zero rows and zero columns count as one
    set_shape(16'd0, 16'd0);
    send_cell(16'h0001);
    send_cell(16'hffff);

    // Top row count, then the grid is reshaped in mid-stream: fewer columns
    // end the current row early, fewer rows make the next row the final one
    set_shape(16'hffff, 16'd3);
    repeat (4) send_cell(pick_value());
    wait_idle();
    cfg_write(REG_NUM_COLS, 16'd2, 1'b0);
    send_cell(pick_value());
    wait_idle();
    cfg_write(REG_NUM_ROWS, 16'd2, 1'b0);
    repeat (2) send_cell(pick_value());

    // Random grids, shape changed every few grids
    grid_no = 0;
    reshape = 1'b1;
    while (items_sent < ITEMS) begin
      grid_no++;
      if (items_sent >= ITEMS - FINAL_GAPLESS) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end else begin
        tx_gaps = ($urandom_range(0, 3) != 0);
        rx_gaps = ($urandom_range(0, 3) != 0);
      end

      if (grid_no == STRESS_GRID) begin
        // results pile up behind a stalled receiver until the input stalls too
        set_shape(16'd1, 16'd1);
        tx_gaps   = 1'b0;
        stall_req = 1'b1;
        repeat (40) send_cell(pick_value());
        stall_req = 1'b0;
        wait_idle();
        reshape = 1'b1;
      end

      // the shape stays fixed in the last part so the stream runs without pauses
      if ((reshape || $urandom_range(0, 2) == 0) && items_sent < ITEMS - FINAL_GAPLESS) begin
        r = $urandom_range(0, 29);
        if (r == 0) begin
          set_shape(16'd0, {7'($urandom), 9'($urandom_range(0, 8))});
        end else if (r == 1) begin
          set_shape(16'($urandom_range(0, 5)), {7'($urandom), 9'd0});
        end else if (r == 2) begin
          // full column store, including counts beyond it
          k = $urandom_range(0, 2);
          set_shape(16'($urandom_range(1, 2)),
                    {7'($urandom), (k == 0) ? 9'd256 : (k == 1) ? 9'd300 : 9'd511});
        end else begin
          set_shape(16'($urandom_range(1, 6)), {7'($urandom), 9'($urandom_range(1, 12))});
        end
        reshape = 1'b0;
      end
      send_grid();
    end

    // Drain and verdict
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    guard = 0;
    while (pending != 0 && guard < END_GUARD) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
